### rtl/core/dmc_pkg.sv
// Package for the direct-mapped write-back cache.
// Holds command codes, register indexes, reset values and the request type.
// No dependencies.
package dmc_pkg;

   localparam int ADDR_W = 20;
   localparam int DATA_W = 32;
   localparam int COST_W = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MEM_READ  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEM_WRITE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_READ  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_WRITE = 2'd3;

   localparam logic [COST_W-1:0] MEM_READ_COST_RST  = 16'd100;
   localparam logic [COST_W-1:0] MEM_WRITE_COST_RST = 16'd50;
   localparam logic [COST_W-1:0] HIT_READ_COST_RST  = 16'd1;
   localparam logic [COST_W-1:0] HIT_WRITE_COST_RST = 16'd1;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   address;
      logic [DATA_W-1:0]   write_data;
   } req_type;

endpackage

### rtl/core/direct_mapped_writeback_cache_unit.sv
// Top level of the direct-mapped write-back cache with its own backing memory.
// Depends on dmc_pkg, dmc_front, dmc_back (which uses dmc_ram).
//
//   channel   ports        handshake           content
//   request   req_*        valid / ready       command, address, write data
//   result    rsp_*        valid / ready       read data, hit flag, elapsed time
//   config    csr_*        write enable only   cost registers 0..3
//
// A read hit passes through the queue pop, the tag read, the data read and the
// result register; a write hit skips the data read, since the word is written in
// the same cycle the result is registered. A miss adds a line fill that reads and
// then writes each word, preceded by a write back of a dirty victim word by word.
// After reset a clearing pass marks every backing memory line as unwritten
// (MEM_BYTES / LINE_BYTES lines, 16384 by default) with req_ready low.
// The two-entry request queue keeps accepting, until both entries are full,
// while the back end works or while the result register waits on rsp_ready.
module direct_mapped_writeback_cache_unit
   import dmc_pkg::*;
#(
   parameter int NUM_LINES  = 256,
   parameter int LINE_BYTES = 64,
   parameter int MEM_BYTES  = 1048576
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_command,
   input  logic [ADDR_W-1:0]    req_address,
   input  logic [DATA_W-1:0]    req_write_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DATA_W-1:0]    rsp_read_data,
   output logic                 rsp_hit,
   output logic [DATA_W-1:0]    rsp_elapsed_time,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COST_W-1:0]    csr_wdata
);

   logic    q_valid, q_pop, accept_en;
   req_type q_item;

   // The front end only decodes and buffers; all cache state lives in the back end.
   dmc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .enable        (accept_en),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_address   (req_address),
      .req_write_data(req_write_data),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   // The back end runs one request at a time and owns the result register, so a
   // finished transfer can wait on rsp_ready without stalling the front end.
   dmc_back #(
      .NUM_LINES (NUM_LINES),
      .LINE_BYTES(LINE_BYTES),
      .MEM_BYTES (MEM_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .accept_en       (accept_en),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_hit         (rsp_hit),
      .rsp_elapsed_time(rsp_elapsed_time)
   );

endmodule

### rtl/core/dmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_ff <= store_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/dmc_front.sv
// Front end: accepts requests, decodes the command and queues them (two entries).
// Depends on dmc_pkg.
module dmc_front
   import dmc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_command,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [DATA_W-1:0] req_write_data,
   output logic              q_valid,
   output req_type           q_item,
   input  logic              q_pop
);

   req_type    entry_ff [2];
   req_type    entry_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       push_head;

   always_comb begin
      entry_in.address    = req_address;
      entry_in.write_data = req_write_data;
      case (req_command)
         CMD_READ:  entry_in.op = OP_READ;
         CMD_WRITE: entry_in.op = OP_WRITE;
         CMD_CLEAR: entry_in.op = OP_CLEAR;
         default:   entry_in.op = OP_NOP;
      endcase
   end

   assign req_ready = enable && (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[0];
   // A new transfer lands in the head slot when the queue is empty or drains to empty.
   assign push_head = push && (count_ff == 2'd0 || (count_ff == 2'd1 && q_pop));

   always_comb begin
      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (q_pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Head is entry 0; a pop shifts entry 1 down.
   always_ff @(posedge clock) begin
      if (push_head) begin
         entry_ff[0] <= entry_in;
      end else if (q_pop) begin
         entry_ff[0] <= entry_ff[1];
      end
      if (push && !push_head) begin
         entry_ff[1] <= entry_in;
      end
   end

endmodule

### rtl/core/dmc_back.sv
// Back end: tag lookup, write-back, line fill, word access, time counter and result register.
// Depends on dmc_pkg and dmc_ram.
module dmc_back
   import dmc_pkg::*;
#(
   parameter int NUM_LINES  = 256,
   parameter int LINE_BYTES = 64,
   parameter int MEM_BYTES  = 1048576
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COST_W-1:0]    csr_wdata,
   input  logic                 q_valid,
   input  req_type              q_item,
   output logic                 q_pop,
   output logic                 accept_en,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DATA_W-1:0]    rsp_read_data,
   output logic                 rsp_hit,
   output logic [DATA_W-1:0]    rsp_elapsed_time
);

   localparam int AW     = $clog2(MEM_BYTES);
   localparam int OFF_W  = $clog2(LINE_BYTES);
   localparam int IDX_W  = $clog2(NUM_LINES);
   localparam int WSEL_W = OFF_W - 2;
   localparam int TAG_W  = AW - OFF_W - IDX_W;
   localparam int ML_W   = TAG_W + IDX_W;
   localparam int WPL    = LINE_BYTES / 4;

   typedef enum logic [8:0] {
      S_CLEAR  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_LOOKUP = 9'b000000100,
      S_WB_RD  = 9'b000001000,
      S_WB_WR  = 9'b000010000,
      S_FL_RD  = 9'b000100000,
      S_FL_WR  = 9'b001000000,
      S_ACCESS = 9'b010000000,
      S_RESP   = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   op_type               op_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [TAG_W-1:0]     tag_ff, old_tag_ff;
   logic [WSEL_W-1:0]    wsel_ff, cnt_ff;
   logic [DATA_W-1:0]    wdata_ff;
   logic                 hit_ff;
   logic [DATA_W-1:0]    time_ff;
   logic [COST_W-1:0]    mem_read_cost_ff, mem_write_cost_ff;
   logic [COST_W-1:0]    hit_read_cost_ff, hit_write_cost_ff;
   logic [NUM_LINES-1:0] valid_ff, dirty_ff;
   logic [ML_W-1:0]      clr_cnt_ff;
   logic                 rsp_valid_ff, rsp_hit_ff;
   logic [DATA_W-1:0]    rsp_read_data_ff, rsp_time_ff;

   logic [AW-1:0]        q_addr;
   logic [IDX_W-1:0]     q_idx;
   logic                 out_free, is_hit, last_word;
   logic                 rsp_load;
   logic [TAG_W-1:0]     tag_rdata;
   logic [DATA_W-1:0]    data_rdata, mem_rdata;
   logic                 written_rdata;
   logic                 data_we, mem_we, wr_we, wr_wdata;
   logic [IDX_W+WSEL_W-1:0] data_waddr, data_raddr;
   logic [DATA_W-1:0]    data_wdata;
   logic [ML_W-1:0]      wr_waddr;

   assign q_addr    = AW'(q_item.address);
   assign q_idx     = q_addr[OFF_W+IDX_W-1:OFF_W];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_hit    = valid_ff[idx_ff] && (tag_rdata == tag_ff);
   assign last_word = (cnt_ff == WSEL_W'(WPL - 1));
   assign accept_en = (state_ff != S_CLEAR);
   assign q_pop     = (state_ff == S_IDLE) && q_valid &&
                      (q_item.op == OP_READ || q_item.op == OP_WRITE || out_free);
   // The result register loads a new result in these cycles.
   assign rsp_load  = (q_pop && q_item.op != OP_READ && q_item.op != OP_WRITE) ||
                      (state_ff == S_ACCESS && op_ff == OP_WRITE && out_free) ||
                      (state_ff == S_RESP && out_free);

   dmc_ram #(.WIDTH(TAG_W), .DEPTH(NUM_LINES)) u_tag_ram (
      .clock(clock),
      .we   ((state_ff == S_FL_WR) && last_word),
      .waddr(idx_ff),
      .wdata(tag_ff),
      .raddr(q_idx),
      .rdata(tag_rdata)
   );

   always_comb begin
      data_we    = 1'b0;
      data_waddr = {idx_ff, cnt_ff};
      data_wdata = written_rdata ? mem_rdata : '0;
      if (state_ff == S_FL_WR) begin
         data_we = 1'b1;
      end else if (state_ff == S_ACCESS && op_ff == OP_WRITE && out_free) begin
         data_we    = 1'b1;
         data_waddr = {idx_ff, wsel_ff};
         data_wdata = wdata_ff;
      end
   end

   assign data_raddr = (state_ff == S_ACCESS || state_ff == S_RESP) ?
                       {idx_ff, wsel_ff} : {idx_ff, cnt_ff};

   dmc_ram #(.WIDTH(DATA_W), .DEPTH(NUM_LINES * WPL)) u_data_ram (
      .clock(clock),
      .we   (data_we),
      .waddr(data_waddr),
      .wdata(data_wdata),
      .raddr(data_raddr),
      .rdata(data_rdata)
   );

   assign mem_we = (state_ff == S_WB_WR);

   dmc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_BYTES / 4)) u_mem_ram (
      .clock(clock),
      .we   (mem_we),
      .waddr({old_tag_ff, idx_ff, cnt_ff}),
      .wdata(data_rdata),
      .raddr({tag_ff, idx_ff, cnt_ff}),
      .rdata(mem_rdata)
   );

   // One bit per memory line: set once the line has been written back.
   // A line never written reads as zero.
   always_comb begin
      wr_we    = 1'b0;
      wr_waddr = {old_tag_ff, idx_ff};
      wr_wdata = 1'b1;
      if (state_ff == S_CLEAR) begin
         wr_we    = 1'b1;
         wr_waddr = clr_cnt_ff;
         wr_wdata = 1'b0;
      end else if (state_ff == S_WB_WR) begin
         wr_we = 1'b1;
      end
   end

   dmc_ram #(.WIDTH(1), .DEPTH(MEM_BYTES / LINE_BYTES)) u_written_ram (
      .clock(clock),
      .we   (wr_we),
      .waddr(wr_waddr),
      .wdata(wr_wdata),
      .raddr({tag_ff, idx_ff}),
      .rdata(written_rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:  if (clr_cnt_ff == {ML_W{1'b1}}) state_in = S_IDLE;
         S_IDLE:   if (q_pop && (q_item.op == OP_READ || q_item.op == OP_WRITE))
                      state_in = S_LOOKUP;
         S_LOOKUP: begin
            if (is_hit) state_in = S_ACCESS;
            else if (valid_ff[idx_ff] && dirty_ff[idx_ff]) state_in = S_WB_RD;
            else state_in = S_FL_RD;
         end
         S_WB_RD:  state_in = S_WB_WR;
         S_WB_WR:  state_in = last_word ? S_FL_RD : S_WB_RD;
         S_FL_RD:  state_in = S_FL_WR;
         S_FL_WR:  state_in = last_word ? S_ACCESS : S_FL_RD;
         S_ACCESS: begin
            if (op_ff == OP_READ) state_in = S_RESP;
            else if (out_free) state_in = S_IDLE;
         end
         S_RESP:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_CLEAR;
         clr_cnt_ff        <= '0;
         valid_ff          <= '0;
         dirty_ff          <= '0;
         time_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
         mem_read_cost_ff  <= MEM_READ_COST_RST;
         mem_write_cost_ff <= MEM_WRITE_COST_RST;
         hit_read_cost_ff  <= HIT_READ_COST_RST;
         hit_write_cost_ff <= HIT_WRITE_COST_RST;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MEM_READ:  mem_read_cost_ff  <= csr_wdata;
               CSR_MEM_WRITE: mem_write_cost_ff <= csr_wdata;
               CSR_HIT_READ:  hit_read_cost_ff  <= csr_wdata;
               CSR_HIT_WRITE: hit_write_cost_ff <= csr_wdata;
               default:       mem_read_cost_ff  <= mem_read_cost_ff;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: clr_cnt_ff <= clr_cnt_ff + 1'b1;
            S_IDLE: begin
               if (q_pop && q_item.op == OP_CLEAR) begin
                  time_ff          <= '0;
                  rsp_time_ff      <= '0;
               end else if (q_pop && q_item.op == OP_NOP) begin
                  rsp_time_ff      <= time_ff;
               end
            end
            S_LOOKUP: begin
               if (!is_hit) begin
                  if (valid_ff[idx_ff] && dirty_ff[idx_ff]) begin
                     time_ff <= time_ff + DATA_W'(mem_read_cost_ff)
                                        + DATA_W'(mem_write_cost_ff);
                  end else begin
                     time_ff <= time_ff + DATA_W'(mem_read_cost_ff);
                  end
               end
            end
            S_FL_WR: begin
               if (last_word) begin
                  valid_ff[idx_ff] <= 1'b1;
                  dirty_ff[idx_ff] <= 1'b0;
               end
            end
            S_ACCESS: begin
               if (op_ff == OP_WRITE && out_free) begin
                  dirty_ff[idx_ff] <= 1'b1;
                  time_ff          <= time_ff + DATA_W'(hit_write_cost_ff);
                  rsp_time_ff      <= time_ff + DATA_W'(hit_write_cost_ff);
               end
            end
            S_RESP: begin
               if (out_free) begin
                  time_ff      <= time_ff + DATA_W'(hit_read_cost_ff);
                  rsp_time_ff  <= time_ff + DATA_W'(hit_read_cost_ff);
               end
            end
            default: clr_cnt_ff <= clr_cnt_ff;
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff    <= q_item.op;
         idx_ff   <= q_idx;
         tag_ff   <= q_addr[AW-1:OFF_W+IDX_W];
         wsel_ff  <= q_addr[OFF_W-1:2];
         wdata_ff <= q_item.write_data;
      end
      if (state_ff == S_LOOKUP) begin
         old_tag_ff <= tag_rdata;
         hit_ff     <= is_hit;
         cnt_ff     <= '0;
      end else if (state_ff == S_WB_WR || state_ff == S_FL_WR) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (state_ff == S_IDLE && q_pop && q_item.op != OP_READ && q_item.op != OP_WRITE) begin
         rsp_read_data_ff <= '0;
         rsp_hit_ff       <= 1'b0;
      end else if (state_ff == S_ACCESS && op_ff == OP_WRITE && out_free) begin
         rsp_read_data_ff <= '0;
         rsp_hit_ff       <= hit_ff;
      end else if (state_ff == S_RESP && out_free) begin
         rsp_read_data_ff <= data_rdata;
         rsp_hit_ff       <= hit_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_elapsed_time = rsp_time_ff;

endmodule

### rtl/core/dmc_checker.sv
// Port-level checker for the cache top level, attached by a bind statement.
// Depends on dmc_pkg and direct_mapped_writeback_cache_unit.
module dmc_checker
   import dmc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_read_data,
   input logic              rsp_hit,
   input logic [DATA_W-1:0] rsp_elapsed_time
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_read_data) && $stable(rsp_hit)
                                  && $stable(rsp_elapsed_time))
      else $error("result changed while stalled");

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during clearing pass");

endmodule

bind direct_mapped_writeback_cache_unit dmc_checker u_dmc_checker (.*);

### dv/tb_direct_mapped_writeback_cache_unit.sv
// Self-checking testbench for the direct-mapped write-back cache unit.
// Depends on dmc_pkg and direct_mapped_writeback_cache_unit; it needs no other
// file and reads no input at run time.
`timescale 1ns / 100ps

module tb_direct_mapped_writeback_cache_unit;
   import dmc_pkg::*;

   // The longest run is a clearing pass followed by ~1600 items, each with a
   // miss, a write back and both stalls.
   localparam int CYCLE_LIMIT = 2000000;
   localparam int MAX_WAIT    = 17;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_command = '0;
   logic [ADDR_W-1:0] req_address = '0;
   logic [DATA_W-1:0] req_write_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [DATA_W-1:0] rsp_read_data;
   logic              rsp_hit;
   logic [DATA_W-1:0] rsp_elapsed_time;
   logic              csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COST_W-1:0] csr_wdata = '0;

   direct_mapped_writeback_cache_unit u_dut (.*);

   always #1 clock = ~clock;

   // One response as the cache should report it.
   typedef struct {
      bit [31:0] read_word;
      bit        hit;
      bit [31:0] elapsed;
   } access_result_type;

   // One row of the directed table. Rows with known_result set carry a
   // response that can be worked out by hand from the reset costs.
   typedef struct {
      op_type    op;
      bit [19:0] addr;
      bit [31:0] wdata;
      bit        known_result;
      bit [31:0] read_word;
      bit        hit;
      bit [31:0] elapsed;
   } directed_row_type;

   // Shadow copy of the cache and its backing memory.
   bit [31:0] shadow_mem [0:262143];
   bit [31:0] shadow_lines [0:4095];
   bit        shadow_valid [0:255];
   bit        shadow_dirty [0:255];
   bit [5:0]  shadow_tag [0:255];
   bit [31:0] shadow_clock;
   bit [15:0] cost_mem_read, cost_mem_write, cost_hit_read, cost_hit_write;

   access_result_type pending_results[$];
   int errors = 0;
   int cycles = 0;
   bit send_quiet = 1'b0;
   bit recv_quiet = 1'b0;
   int recv_wait = 0;
   int transfers_seen = 0;

   // Works out the response of one access and updates the shadow state.
   function automatic access_result_type model_access(op_type op, bit [19:0] addr,
                                                      bit [31:0] wdata);
      access_result_type r;
      bit [3:0]  word;
      bit [7:0]  idx;
      bit [5:0]  tag;
      bit [17:0] base;
      r = '{0, 0, 0};
      word = addr[5:2];
      idx  = addr[13:6];
      tag  = addr[19:14];
      if (op == OP_CLEAR) begin
         shadow_clock = 0;
      end else if (op == OP_READ || op == OP_WRITE) begin
         if (shadow_valid[idx] && shadow_tag[idx] == tag) begin
            r.hit = 1'b1;
         end else begin
            shadow_clock += cost_mem_read;
            // A dirty victim goes back to its own line before the fill.
            if (shadow_valid[idx] && shadow_dirty[idx]) begin
               base = {shadow_tag[idx], idx, 4'b0};
               for (int i = 0; i < 16; i++)
                  shadow_mem[base + i] = shadow_lines[{idx, 4'b0} + i];
               shadow_clock += cost_mem_write;
            end
            base = {tag, idx, 4'b0};
            for (int i = 0; i < 16; i++)
               shadow_lines[{idx, 4'b0} + i] = shadow_mem[base + i];
            shadow_valid[idx] = 1'b1;
            shadow_tag[idx] = tag;
            shadow_dirty[idx] = 1'b0;
         end
         if (op == OP_READ) begin
            r.read_word = shadow_lines[{idx, word}];
            shadow_clock += cost_hit_read;
         end else begin
            shadow_lines[{idx, word}] = wdata;
            shadow_clock += cost_hit_write;
            shadow_dirty[idx] = 1'b1;
         end
      end
      r.elapsed = shadow_clock;
      return r;
   endfunction

   // Presents one request, waits for its transfer and records what should
   // come back. A gap of zero keeps req_valid high into the next request.
   task automatic send_access(op_type op, bit [19:0] addr, bit [31:0] wdata,
                              bit known, access_result_type known_res);
      int gap;
      access_result_type r;
      gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= op;
      req_address <= addr;
      req_write_data <= wdata;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      r = model_access(op, addr, wdata);
      pending_results.push_back(known ? known_res : r);
   endtask

   // Lowers req_valid and waits until every expected response has arrived.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Writes all four cost registers while the cache is idle.
   task automatic program_costs(bit [15:0] mr, bit [15:0] mw, bit [15:0] hr,
                                bit [15:0] hw);
      bit [15:0] vals [4];
      vals = '{mr, mw, hr, hw};
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_index <= i[CSR_IDX_W-1:0];
         csr_wdata <= vals[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
      cost_mem_read = mr;
      cost_mem_write = mw;
      cost_hit_read = hr;
      cost_hit_write = hw;
   endtask

   // Addresses mostly fall on a few tags and a few lines at either end of the
   // index range, so hits, conflict misses and dirty write backs are common.
   function automatic bit [19:0] pick_address();
      bit [5:0] tag;
      bit [7:0] idx;
      if ($urandom_range(0, 9) < 3)
         return 20'($urandom_range(0, 20'hFFFFF));
      tag = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(60, 63))
                                        : 6'($urandom_range(0, 3));
      idx = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(248, 255));
      return {tag, idx, 6'(($urandom_range(0, 63)))};
   endfunction

   task automatic run_random(int count);
      op_type op;
      int pick;
      for (int n = 0; n < count; n++) begin
         if (n % 48 == 0) send_quiet = ($urandom_range(0, 3) == 0);
         // Hold off once in each phase until everything has come back.
         if (n == count / 2) drain_results();
         pick = $urandom_range(0, 99);
         if (pick < 48)      op = OP_READ;
         else if (pick < 92) op = OP_WRITE;
         else if (pick < 97) op = OP_CLEAR;
         else                op = OP_NOP;
         send_access(op, pick_address(), $urandom(), 1'b0, '{0, 0, 0});
      end
   endtask

   // Response side: a random stall before each response, with stall-free
   // stretches now and then.
   always @(negedge clock) begin
      if (recv_wait > 0) begin
         recv_wait <= recv_wait - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Checks each response transfer against the oldest expectation.
   always @(posedge clock) begin
      access_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         transfers_seen++;
         if (transfers_seen % 40 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
         recv_wait <= recv_quiet ? 0 : $urandom_range(0, MAX_WAIT);
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response: data %h hit %b time %0d",
                        rsp_read_data, rsp_hit, rsp_elapsed_time);
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_read_data !== exp_r.read_word || rsp_hit !== exp_r.hit ||
                rsp_elapsed_time !== exp_r.elapsed) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: data %h/%h hit %b/%b time %0d/%0d (exp/got)",
                           exp_r.read_word, rsp_read_data, exp_r.hit, rsp_hit,
                           exp_r.elapsed, rsp_elapsed_time);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[direct_mapped_writeback_cache_unit] ERROR");
         $finish;
      end
   end

   initial begin
      directed_row_type rows [14];
      cost_mem_read = MEM_READ_COST_RST;
      cost_mem_write = MEM_WRITE_COST_RST;
      cost_hit_read = HIT_READ_COST_RST;
      cost_hit_write = HIT_WRITE_COST_RST;
      shadow_clock = 0;

      // Hand-worked rows use the reset costs: fill 100, write back 50, hit 1.
      rows = '{
         '{OP_READ,  20'h00000, 32'h0,        1, 32'h0,        0, 101},
         '{OP_READ,  20'h00003, 32'h0,        1, 32'h0,        1, 102},
         '{OP_WRITE, 20'hFFFFF, 32'hFFFFFFFF, 1, 32'h0,        0, 203},
         '{OP_READ,  20'hFFFFC, 32'h0,        1, 32'hFFFFFFFF, 1, 204},
         // Same line, other tag: the dirty victim is written back first.
         '{OP_WRITE, 20'h03FC0, 32'h5A5A5A5A, 1, 32'h0,        0, 355},
         '{OP_READ,  20'hFFFFD, 32'h0,        1, 32'hFFFFFFFF, 0, 506},
         '{OP_CLEAR, 20'h00000, 32'h0,        1, 32'h0,        0, 0},
         '{OP_NOP,   20'h12345, 32'hFFFFFFFF, 1, 32'h0,        0, 0},
         '{OP_READ,  20'h03FC2, 32'h0,        0, 0, 0, 0},
         '{OP_WRITE, 20'h00004, 32'h00000001, 0, 0, 0, 0},
         '{OP_READ,  20'h40004, 32'h0,        0, 0, 0, 0},
         '{OP_READ,  20'h00007, 32'h0,        0, 0, 0, 0},
         '{OP_WRITE, 20'hAAAAA, 32'hAAAAAAAA, 0, 0, 0, 0},
         '{OP_READ,  20'h55555, 32'h55555555, 0, 0, 0, 0}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send_access(rows[i].op, rows[i].addr, rows[i].wdata, rows[i].known_result,
                     '{rows[i].read_word, rows[i].hit, rows[i].elapsed});
      drain_results();

      program_costs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      run_random(384);
      drain_results();
      program_costs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random(384);
      drain_results();
      program_costs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      run_random(384);
      drain_results();
      program_costs(MEM_READ_COST_RST, MEM_WRITE_COST_RST, 16'($urandom_range(0, 9)),
                    16'($urandom_range(0, 9)));
      run_random(384);
      drain_results();

      repeat (100) @(posedge clock);
      if (pending_results.size() != 0) errors++;
      if (errors == 0) begin
         $display("[direct_mapped_writeback_cache_unit] OK");
      end else begin
         $display("[direct_mapped_writeback_cache_unit] ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/dmc_pkg.sv
rtl/core/dmc_ram.sv
rtl/core/dmc_front.sv
rtl/core/dmc_back.sv
rtl/core/direct_mapped_writeback_cache_unit.sv
rtl/core/dmc_checker.sv
dv/tb_direct_mapped_writeback_cache_unit.sv
